[sv/ttc_pkg.sv]
// Shared types and constants for the teletype text console.
// Holds the item structs, function and control codes, and the controller states.
package ttc_pkg;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [6:0] column;
        logic [4:0] row;
    } t_ttc_in;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [6:0] cursor_column;
        logic [4:0] cursor_row;
        logic       scrolled;
    } t_ttc_out;

    localparam logic [1:0] FUNC_TTY    = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_SETCUR = 2'd2;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] TEXT_ATTR = 8'h0F;

    localparam int CELL_W = 16;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_READ,
        ST_DONE
    } t_ttc_state;

endpackage

[sv/ttc_cell_ram.sv]
// Cell memory of the text console: one write port, one read port, registered read data.
// Depends on ttc_pkg for the cell width.
module ttc_cell_ram #(
    parameter int DEPTH = 16000,
    parameter int AW    = 14
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [ttc_pkg::CELL_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [ttc_pkg::CELL_W-1:0] o_rdata
);

    logic [ttc_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [ttc_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/teletype_text_console_unit.sv]
// Top level of the teletype text console: controller, cursors and scroll sequencer.
// Depends on ttc_pkg and ttc_cell_ram.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------
//  in      | input     | i_in_valid/o_in_stall | i_in_item  (t_ttc_in)
//  out     | output    | o_out_valid/i_out_stall | o_out_item (t_ttc_out)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (active page)
//
// An accepted item passes through the EXEC and READ states to DONE, where its result
// enters the output register once that is free; the next item is taken only back in
// IDLE. A step that scrolls goes through SCROLL before READ, one cell per cycle
// through the single read port. After reset a clearing pass writes every cell to
// zero, during which no item is accepted; config writes are taken always.
// A result waits in the output register while the next item is worked on.
module teletype_text_console_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int PAGES   = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ttc_pkg::t_ttc_in  i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output ttc_pkg::t_ttc_out o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_data
);

    localparam int PAGE_CELLS = COLUMNS * ROWS;
    localparam int DEPTH      = PAGES * PAGE_CELLS;
    localparam int AW         = $clog2(DEPTH);
    localparam int CNW        = $clog2(PAGE_CELLS);
    localparam int XW         = $clog2(COLUMNS);
    localparam int YW         = $clog2(ROWS);
    localparam int PW         = (PAGES > 1) ? $clog2(PAGES) : 1;

    function automatic logic [AW-1:0] cell_addr(input logic [PW-1:0] p,
                                                 input logic [YW-1:0] y,
                                                 input logic [XW-1:0] x);
        return AW'(p * PAGE_CELLS + y * COLUMNS + x);
    endfunction

    ttc_pkg::t_ttc_state r_state, n_state;

    logic [2:0]    r_active_page;
    logic [XW-1:0] r_cur_col [PAGES];
    logic [YW-1:0] r_cur_row [PAGES];

    logic [1:0]    r_func, n_func;
    logic [7:0]    r_char, n_char;
    logic [XW-1:0] r_rcol, n_rcol;
    logic [YW-1:0] r_rrow, n_rrow;
    logic [PW-1:0] r_page, n_page;

    logic [AW-1:0]  r_sc_addr, n_sc_addr;
    logic [CNW-1:0] r_sc_cnt, n_sc_cnt;
    logic           r_wr_valid, n_wr_valid;
    logic           r_wr_zero, n_wr_zero;
    logic [AW-1:0]  r_wr_addr, n_wr_addr;
    logic [AW-1:0]  r_rd_addr, n_rd_addr;
    logic [XW-1:0]  r_fcol, n_fcol;
    logic [YW-1:0]  r_frow, n_frow;
    logic           r_scrolled, n_scrolled;
    logic           r_out_valid, n_out_valid;
    ttc_pkg::t_ttc_out r_out, n_out;

    logic                       cur_we;
    logic                       mem_we, mem_re;
    logic [AW-1:0]              mem_waddr, mem_raddr;
    logic [ttc_pkg::CELL_W-1:0] mem_wdata, mem_rdata;

    ttc_cell_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        logic [4:0]    pm;
        logic [XW-1:0] c;
        logic [YW-1:0] y;
        logic [XW-1:0] fc;
        logic [YW-1:0] fy;
        logic          scr;

        n_state     = r_state;
        n_func      = r_func;
        n_char      = r_char;
        n_rcol      = r_rcol;
        n_rrow      = r_rrow;
        n_page      = r_page;
        n_sc_addr   = r_sc_addr;
        n_sc_cnt    = r_sc_cnt;
        n_wr_valid  = 1'b0;
        n_wr_zero   = r_wr_zero;
        n_wr_addr   = r_wr_addr;
        n_rd_addr   = r_rd_addr;
        n_fcol      = r_fcol;
        n_frow      = r_frow;
        n_scrolled  = r_scrolled;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        cur_we      = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = r_rd_addr;
        mem_we      = r_wr_valid;
        mem_waddr   = r_wr_addr;
        mem_wdata   = r_wr_zero ? '0 : mem_rdata;

        // page modulo PAGES, value is below 8
        pm = {2'b00, r_active_page};
        for (int i = 0; i < 8; i++) begin
            if (int'(pm) >= PAGES) begin
                pm = pm - 5'(PAGES);
            end
        end

        c   = r_cur_col[r_page];
        y   = r_cur_row[r_page];
        fc  = c;
        fy  = y;
        scr = 1'b0;

        case (r_state)
            ttc_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_sc_addr;
                mem_wdata = '0;
                n_sc_addr = r_sc_addr + AW'(1);
                if (r_sc_addr == AW'(DEPTH - 1)) begin
                    n_state = ttc_pkg::ST_IDLE;
                end
            end
            ttc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_func = i_in_item.func;
                    n_char = i_in_item.char_code;
                    n_rcol = (int'(i_in_item.column) >= COLUMNS) ? XW'(COLUMNS - 1)
                                                                 : XW'(i_in_item.column);
                    n_rrow = (int'(i_in_item.row) >= ROWS) ? YW'(ROWS - 1)
                                                           : YW'(i_in_item.row);
                    n_page  = PW'(pm);
                    n_state = ttc_pkg::ST_EXEC;
                end
            end
            ttc_pkg::ST_EXEC: begin
                case (r_func)
                    ttc_pkg::FUNC_TTY: begin
                        cur_we = 1'b1;
                        if (r_char == ttc_pkg::CH_BS) begin
                            if (c != '0) begin
                                fc = c - XW'(1);
                            end
                        end else if (r_char == ttc_pkg::CH_LF) begin
                            if (y == YW'(ROWS - 1)) begin
                                scr = 1'b1;
                            end else begin
                                fy = y + YW'(1);
                            end
                        end else if (r_char == ttc_pkg::CH_CR) begin
                            fc = '0;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(r_page, y, c);
                            mem_wdata = {ttc_pkg::TEXT_ATTR, r_char};
                            if (c == XW'(COLUMNS - 1)) begin
                                fc = '0;
                                if (y == YW'(ROWS - 1)) begin
                                    scr = 1'b1;
                                end else begin
                                    fy = y + YW'(1);
                                end
                            end else begin
                                fc = c + XW'(1);
                            end
                        end
                    end
                    ttc_pkg::FUNC_SETCUR: begin
                        cur_we = 1'b1;
                        fc     = r_rcol;
                        fy     = r_rrow;
                    end
                    default: begin
                    end
                endcase
                n_fcol     = fc;
                n_frow     = fy;
                n_scrolled = scr;
                n_rd_addr  = (r_func == ttc_pkg::FUNC_READ) ? cell_addr(r_page, r_rrow, r_rcol)
                                                            : cell_addr(r_page, fy, fc);
                n_sc_addr  = cell_addr(r_page, '0, '0);
                n_sc_cnt   = '0;
                n_state    = scr ? ttc_pkg::ST_SCROLL : ttc_pkg::ST_READ;
            end
            ttc_pkg::ST_SCROLL: begin
                // read one row below, write it back in the next cycle; bottom row gets zeros
                mem_re     = (int'(r_sc_cnt) < PAGE_CELLS - COLUMNS);
                mem_raddr  = r_sc_addr + AW'(COLUMNS);
                n_wr_valid = 1'b1;
                n_wr_addr  = r_sc_addr;
                n_wr_zero  = !mem_re;
                n_sc_addr  = r_sc_addr + AW'(1);
                n_sc_cnt   = r_sc_cnt + CNW'(1);
                if (r_sc_cnt == CNW'(PAGE_CELLS - 1)) begin
                    n_state = ttc_pkg::ST_READ;
                end
            end
            ttc_pkg::ST_READ: begin
                // hold off while the last scroll write lands
                if (!r_wr_valid) begin
                    mem_re  = 1'b1;
                    n_state = ttc_pkg::ST_DONE;
                end
            end
            ttc_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid         = 1'b1;
                    n_out.cell_char     = mem_rdata[7:0];
                    n_out.cell_attr     = mem_rdata[15:8];
                    n_out.cursor_column = 7'(r_fcol);
                    n_out.cursor_row    = 5'(r_frow);
                    n_out.scrolled      = r_scrolled;
                    n_state             = ttc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ttc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttc_pkg::ST_CLEAR;
            r_sc_addr   <= '0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sc_addr   <= n_sc_addr;
            r_wr_valid  <= n_wr_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_char     <= n_char;
        r_rcol     <= n_rcol;
        r_rrow     <= n_rrow;
        r_page     <= n_page;
        r_sc_cnt   <= n_sc_cnt;
        r_wr_zero  <= n_wr_zero;
        r_wr_addr  <= n_wr_addr;
        r_rd_addr  <= n_rd_addr;
        r_fcol     <= n_fcol;
        r_frow     <= n_frow;
        r_scrolled <= n_scrolled;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_page <= '0;
            for (int i = 0; i < PAGES; i++) begin
                r_cur_col[i] <= '0;
                r_cur_row[i] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_active_page <= i_cfg_data;
            end
            if (cur_we) begin
                r_cur_col[r_page] <= n_fcol;
                r_cur_row[r_page] <= n_frow;
            end
        end
    end

    assign o_in_stall  = (r_state != ttc_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

[tb/tb_teletype_text_console_unit.sv]
// Self-checking testbench for teletype_text_console_unit: directed table, then random
// items over four handshake phases, checked against a screen and cursor predictor.
// Depends on ttc_pkg and the RTL of the console unit.
module tb_teletype_text_console_unit;

    localparam int COLS        = 80;
    localparam int ROWS        = 25;
    localparam int PAGES       = 8;
    localparam int PAGE_CELLS  = COLS * ROWS;
    localparam int QUIET_LIMIT = 60000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 75;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        ttc_pkg::t_ttc_in  stim;
        logic              fixed;
        ttc_pkg::t_ttc_out want;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    ttc_pkg::t_ttc_in   i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    ttc_pkg::t_ttc_out  o_out_item;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [2:0] i_cfg_data = '0;

    // predictor state
    logic [15:0] screen [0:PAGES*PAGE_CELLS-1];
    logic [6:0]  page_col [0:PAGES-1];
    logic [4:0]  page_row [0:PAGES-1];
    logic [2:0]  sel_page;

    ttc_pkg::t_ttc_out pending_results [$];
    t_dir_row dir_rows [$];
    int       mismatches = 0;
    int       in_idle_pct = 0;
    int       out_stall_pct = 0;
    logic     hold_request = 1'b0;
    logic     hold_done = 1'b0;
    int       hold_left = 0;
    int       quiet_cycles = 0;

    logic [2:0] phase_page      [4] = '{3'd7, 3'd0, 3'd7, 3'd4};
    int         phase_in_idle   [4] = '{0, 75, 0, 33};
    int         phase_out_stall [4] = '{0, 0, 75, 33};

    teletype_text_console_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic ttc_pkg::t_ttc_in stim(logic [1:0] f, logic [7:0] ch, logic [6:0] c,
                                              logic [4:0] r);
        ttc_pkg::t_ttc_in it;
        it.func      = f;
        it.char_code = ch;
        it.column    = c;
        it.row       = r;
        return it;
    endfunction

    function automatic ttc_pkg::t_ttc_out want(logic [7:0] ch, logic [7:0] attr,
                                               logic [6:0] c, logic [4:0] r, logic scr);
        ttc_pkg::t_ttc_out o;
        o.cell_char     = ch;
        o.cell_attr     = attr;
        o.cursor_column = c;
        o.cursor_row    = r;
        o.scrolled      = scr;
        return o;
    endfunction

    // Applies one item to the screen and cursor of the selected page.
    function automatic ttc_pkg::t_ttc_out console_step(ttc_pkg::t_ttc_in it);
        int          base;
        int          col;
        int          row;
        int          rd_col;
        int          rd_row;
        int          k;
        logic        scr;
        logic [15:0] cell_word;
        base = int'(sel_page) * PAGE_CELLS;
        col  = page_col[sel_page];
        row  = page_row[sel_page];
        scr  = 1'b0;
        rd_col = (it.column >= COLS) ? COLS - 1 : int'(it.column);
        rd_row = (it.row >= ROWS) ? ROWS - 1 : int'(it.row);
        if (it.func == ttc_pkg::FUNC_TTY) begin
            if (it.char_code == ttc_pkg::CH_BS) begin
                if (col > 0)
                    col--;
            end else if (it.char_code == ttc_pkg::CH_LF) begin
                row++;
            end else if (it.char_code == ttc_pkg::CH_CR) begin
                col = 0;
            end else begin
                screen[base + row*COLS + col] = {ttc_pkg::TEXT_ATTR, it.char_code};
                col++;
                if (col > COLS - 1) begin
                    col = 0;
                    row++;
                end
            end
            if (row > ROWS - 1) begin
                for (k = 0; k < PAGE_CELLS - COLS; k++)
                    screen[base + k] = screen[base + k + COLS];
                for (k = PAGE_CELLS - COLS; k < PAGE_CELLS; k++)
                    screen[base + k] = '0;
                row--;
                scr = 1'b1;
            end
            page_col[sel_page] = 7'(col);
            page_row[sel_page] = 5'(row);
        end else if (it.func == ttc_pkg::FUNC_SETCUR) begin
            col = rd_col;
            row = rd_row;
            page_col[sel_page] = 7'(col);
            page_row[sel_page] = 5'(row);
        end
        if (it.func == ttc_pkg::FUNC_READ)
            cell_word = screen[base + rd_row*COLS + rd_col];
        else
            cell_word = screen[base + row*COLS + col];
        return want(cell_word[7:0], cell_word[15:8], 7'(col), 5'(row), scr);
    endfunction

    // Mostly text and line controls near the bottom rows, so scrolls come often.
    function automatic ttc_pkg::t_ttc_in random_item();
        ttc_pkg::t_ttc_in it;
        int      pick;
        it   = stim(ttc_pkg::FUNC_TTY, 8'($urandom), 7'($urandom), 5'($urandom));
        pick = $urandom_range(99);
        if (pick < 40) begin
            it.func = ttc_pkg::FUNC_TTY;
        end else if (pick < 50) begin
            it.char_code = ttc_pkg::CH_LF;
        end else if (pick < 55) begin
            it.char_code = ttc_pkg::CH_CR;
        end else if (pick < 62) begin
            it.char_code = ttc_pkg::CH_BS;
        end else if (pick < 78) begin
            it.func = ttc_pkg::FUNC_READ;
            if ($urandom_range(99) < 60) begin
                it.row    = page_row[sel_page];
                it.column = 7'($urandom_range(COLS - 1));
            end
        end else if (pick < 95) begin
            it.func = ttc_pkg::FUNC_SETCUR;
            if ($urandom_range(99) < 70) begin
                it.row    = 5'($urandom_range(ROWS - 1, ROWS - 5));
                it.column = 7'($urandom_range(COLS - 1, COLS - 20));
            end
        end else begin
            it.func = FUNC_UNUSED;
        end
        return it;
    endfunction

    task automatic send_item(ttc_pkg::t_ttc_in it, logic fixed, ttc_pkg::t_ttc_out exp_out);
        ttc_pkg::t_ttc_out pred;
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pred = console_step(it);
        pending_results.push_back(fixed ? exp_out : pred);
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_page(logic [2:0] pg);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= pg;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        sel_page = pg;
    endtask

    // result side: check, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        ttc_pkg::t_ttc_out got;
        ttc_pkg::t_ttc_out exp_out;
        if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            got = o_out_item;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected item char %h attr %h col %0d row %0d scr %0b",
                         $time, got.cell_char, got.cell_attr, got.cursor_column,
                         got.cursor_row, got.scrolled);
            end else begin
                exp_out = pending_results.pop_front();
                if (got !== exp_out) begin
                    mismatches++;
                    $display("%0t: mismatch expected char %h attr %h col %0d row %0d scr %0b",
                             $time, exp_out.cell_char, exp_out.cell_attr,
                             exp_out.cursor_column, exp_out.cursor_row, exp_out.scrolled);
                    $display("%0t:          actual   char %h attr %h col %0d row %0d scr %0b",
                             $time, got.cell_char, got.cell_attr, got.cursor_column,
                             got.cursor_row, got.scrolled);
                end
            end
        end
        if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // watchdog: cycles in which no channel moves anything
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int k;
        int p;
        for (k = 0; k < PAGES*PAGE_CELLS; k++)
            screen[k] = '0;
        for (k = 0; k < PAGES; k++) begin
            page_col[k] = '0;
            page_row[k] = '0;
        end
        sel_page = '0;

        // fresh screen, page 0, cursor at the origin
        dir_rows.push_back('{stim(ttc_pkg::FUNC_READ, 8'h00, 7'd0, 5'd0), 1'b1,
                             want(8'h00, 8'h00, 7'd0, 5'd0, 1'b0)});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_READ, 8'hFF, 7'd127, 5'd31), 1'b1,
                             want(8'h00, 8'h00, 7'd0, 5'd0, 1'b0)});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_TTY, ttc_pkg::CH_BS, 7'd0, 5'd0), 1'b1,
                             want(8'h00, 8'h00, 7'd0, 5'd0, 1'b0)});
        dir_rows.push_back('{stim(FUNC_UNUSED, 8'hFF, 7'd127, 5'd31), 1'b1,
                             want(8'h00, 8'h00, 7'd0, 5'd0, 1'b0)});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_TTY, 8'h41, 7'd0, 5'd0), 1'b1,
                             want(8'h00, 8'h00, 7'd1, 5'd0, 1'b0)});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_READ, 8'h00, 7'd0, 5'd0), 1'b1,
                             want(8'h41, ttc_pkg::TEXT_ATTR, 7'd1, 5'd0, 1'b0)});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_TTY, 8'hFF, 7'd0, 5'd0), 1'b0, '0});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_TTY, 8'h00, 7'd0, 5'd0), 1'b0, '0});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_TTY, ttc_pkg::CH_BS, 7'd0, 5'd0), 1'b0, '0});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_TTY, ttc_pkg::CH_CR, 7'd0, 5'd0), 1'b0, '0});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_TTY, ttc_pkg::CH_LF, 7'd0, 5'd0), 1'b0, '0});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_READ, 8'h00, 7'd2, 5'd0), 1'b0, '0});
        // cursor saturation at the boundary and at all ones
        dir_rows.push_back('{stim(ttc_pkg::FUNC_SETCUR, 8'h00, 7'd80, 5'd25), 1'b1,
                             want(8'h00, 8'h00, 7'd79, 5'd24, 1'b0)});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_SETCUR, 8'h00, 7'd127, 5'd31), 1'b1,
                             want(8'h00, 8'h00, 7'd79, 5'd24, 1'b0)});
        // last cell: wrap past the bottom row scrolls
        dir_rows.push_back('{stim(ttc_pkg::FUNC_TTY, 8'h5A, 7'd0, 5'd0), 1'b1,
                             want(8'h00, 8'h00, 7'd0, 5'd24, 1'b1)});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_READ, 8'h00, 7'd79, 5'd23), 1'b1,
                             want(8'h5A, ttc_pkg::TEXT_ATTR, 7'd0, 5'd24, 1'b0)});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_READ, 8'h00, 7'd0, 5'd0), 1'b0, '0});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_TTY, ttc_pkg::CH_LF, 7'd0, 5'd0), 1'b0, '0});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_SETCUR, 8'h00, 7'd79, 5'd0), 1'b0, '0});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_TTY, 8'h20, 7'd0, 5'd0), 1'b0, '0});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_READ, 8'h00, 7'd40, 5'd31), 1'b0, '0});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_READ, 8'h00, 7'd127, 5'd5), 1'b0, '0});
        dir_rows.push_back('{stim(ttc_pkg::FUNC_SETCUR, 8'hFF, 7'd0, 5'd0), 1'b0, '0});
        dir_rows.push_back('{stim(FUNC_UNUSED, 8'h55, 7'd5, 5'd5), 1'b0, '0});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < dir_rows.size(); k++)
            send_item(dir_rows[k].stim, dir_rows[k].fixed, dir_rows[k].want);
        i_in_valid <= 1'b0;

        for (p = 0; p < 4; p++) begin
            wait_idle();
            write_page(phase_page[p]);
            in_idle_pct    = phase_in_idle[p];
            out_stall_pct <= phase_out_stall[p];
            // first phase: long receiver hold while items keep coming
            if (p == 0)
                hold_request <= 1'b1;
            repeat (PHASE_ITEMS)
                send_item(random_item(), 1'b0, '0);
            i_in_valid <= 1'b0;
        end

        wait_idle();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
